[rtl/iffu_pkg.sv]
// ----------------------------------------------------------------------------
// Integer field formatter package
// Shared types, character codes and conversion kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package iffu_pkg;

  localparam int unsigned NumDigits   = 22;
  localparam int unsigned InDataWidth = 88;
  localparam logic [5:0]  WidthLimit  = 6'd60;

  localparam logic [1:0] KindSdec = 2'd0;
  localparam logic [1:0] KindUdec = 2'd1;
  localparam logic [1:0] KindHex  = 2'd2;
  localparam logic [1:0] KindOct  = 2'd3;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChLowX  = 8'h78;

  typedef struct packed {
    logic [NumDigits-1:0][3:0] digits;
    logic [4:0]                nd;
    logic                      has_sign;
    logic [7:0]                sign_ch;
    logic [1:0]                pfx_len;
    logic                      upper;
    logic                      left;
    logic                      zpad;
    logic [5:0]                width;
    logic [5:0]                prec;
  } job_t;

endpackage

`default_nettype wire

[rtl/iffu_front.sv]
// ----------------------------------------------------------------------------
// Integer field formatter front end
// Accepts items, derives sign, prefix and magnitude, and converts the
// magnitude to digits (two binary bits per cycle for decimal kinds).
// ----------------------------------------------------------------------------
`default_nettype none

module iffu_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [iffu_pkg::InDataWidth-1:0] in_data_i,
  output logic                                 push_o,
  output iffu_pkg::job_t                       job_o,
  input  wire logic                            full_i
);

  localparam logic [1:0] FIdle = 2'd0;
  localparam logic [1:0] FConv = 2'd1;
  localparam logic [1:0] FFin  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [4:0]  cnt_q;
  logic [63:0] sr_q;
  logic [87:0] dig_q;
  iffu_pkg::job_t job_q;

  logic [63:0] value, neg_v, mag;
  logic [1:0]  kind;
  logic [5:0]  w_in, p_in;
  logic [65:0] ext;
  logic [87:0] oct_dig;
  logic [79:0] bcd_a, bcd_b;
  logic [4:0]  nd;
  logic        accept;

  function automatic logic [79:0] dabble(input logic [79:0] b, input logic bit_in);
    logic [79:0] t;
    t = b;
    for (int i = 0; i < 20; i++) begin
      if (t[i*4 +: 4] >= 4'd5) begin
        t[i*4 +: 4] = t[i*4 +: 4] + 4'd3;
      end
    end
    return {t[78:0], bit_in};
  endfunction

  assign value  = in_data_i[63:0];
  assign kind   = in_data_i[65:64];
  assign w_in   = (in_data_i[79:74] > iffu_pkg::WidthLimit) ? iffu_pkg::WidthLimit
                                                             : in_data_i[79:74];
  assign p_in   = (in_data_i[85:80] > iffu_pkg::WidthLimit) ? iffu_pkg::WidthLimit
                                                             : in_data_i[85:80];
  assign neg_v  = 64'd0 - value;

  always_comb begin
    mag = (kind == iffu_pkg::KindSdec && value[63]) ? neg_v : value;
    if (!in_data_i[66]) begin
      mag = {32'd0, mag[31:0]};
    end
  end

  assign ext = {2'b00, mag};
  always_comb begin
    for (int i = 0; i < 22; i++) begin
      oct_dig[i*4 +: 4] = {1'b0, ext[i*3 +: 3]};
    end
  end

  assign bcd_a = dabble(dig_q[79:0], sr_q[63]);
  assign bcd_b = dabble(bcd_a, sr_q[62]);

  always_comb begin
    nd = 5'd1;
    for (int i = 1; i < 22; i++) begin
      if (dig_q[i*4 +: 4] != 4'd0) begin
        nd = 5'(i + 1);
      end
    end
  end

  assign in_ready_o = (state_q == FIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = (state_q == FFin) && !full_i;

  always_comb begin
    job_o        = job_q;
    job_o.digits = dig_q;
    job_o.nd     = nd;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FIdle: begin
        if (accept) begin
          state_d = (kind[1]) ? FFin : FConv;
        end
      end
      FConv: begin
        if (cnt_q == 5'd31) begin
          state_d = FFin;
        end
      end
      FFin: begin
        if (!full_i) begin
          state_d = FIdle;
        end
      end
      default: state_d = FIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cnt_q <= 5'd0;
      sr_q  <= mag;
      unique case (kind)
        iffu_pkg::KindHex: dig_q <= {24'd0, mag};
        iffu_pkg::KindOct: dig_q <= oct_dig;
        default:           dig_q <= 88'd0;
      endcase
      job_q.has_sign <= 1'b0;
      job_q.sign_ch  <= iffu_pkg::ChSpace;
      if (kind == iffu_pkg::KindSdec) begin
        if (value[63]) begin
          job_q.has_sign <= 1'b1;
          job_q.sign_ch  <= iffu_pkg::ChMinus;
        end else if (value != 64'd0) begin
          if (in_data_i[69]) begin
            job_q.has_sign <= 1'b1;
            job_q.sign_ch  <= iffu_pkg::ChPlus;
          end else if (in_data_i[70]) begin
            job_q.has_sign <= 1'b1;
          end
        end
      end
      job_q.pfx_len <= 2'd0;
      if (in_data_i[71] && (mag != 64'd0 || in_data_i[72])) begin
        if (kind == iffu_pkg::KindHex) begin
          job_q.pfx_len <= 2'd2;
        end else if (kind == iffu_pkg::KindOct) begin
          job_q.pfx_len <= 2'd1;
        end
      end
      job_q.upper  <= in_data_i[73] && (kind == iffu_pkg::KindHex);
      job_q.left   <= in_data_i[67];
      job_q.zpad   <= in_data_i[68] && !in_data_i[67];
      job_q.width  <= w_in;
      job_q.prec   <= p_in;
      job_q.digits <= '0;
      job_q.nd     <= 5'd0;
    end else if (state_q == FConv) begin
      cnt_q <= cnt_q + 5'd1;
      sr_q  <= {sr_q[61:0], 2'b00};
      dig_q <= {8'd0, bcd_b};
    end
  end

endmodule

`default_nettype wire

[rtl/iffu_queue.sv]
// ----------------------------------------------------------------------------
// Integer field formatter job queue
// Two-entry queue of converted jobs between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module iffu_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  iffu_pkg::job_t      job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output iffu_pkg::job_t      job_o,
  output logic                empty_o
);

  iffu_pkg::job_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign job_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

[rtl/iffu_back.sv]
// ----------------------------------------------------------------------------
// Integer field formatter back end
// Lays out one field and emits its characters through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module iffu_back (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  iffu_pkg::job_t job_i,
  input  wire logic      empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output logic [7:0]     out_char_o,
  output logic           out_last_o
);

  localparam logic BIdle = 1'b0;
  localparam logic BRun  = 1'b1;

  logic state_q;
  logic [5:0] k_q, b1_q, b2_q, b3_q, b4_q, b5_q, n_q;
  logic [iffu_pkg::NumDigits-1:0][3:0] dig_q;
  logic [7:0] sign_q;
  logic upper_q;
  logic ovalid_q, olast_q;
  logic [7:0] ochar_q;

  logic [5:0] body, p0, p, pad, lead, trail, b1, b2, b3, b4, b5, n;
  logic [5:0] didx6;
  logic [3:0] d;
  logic [7:0] dch, ch;
  logic emit, last;

  always_comb begin
    body  = {1'b0, job_i.nd} + {5'd0, job_i.has_sign};
    p0    = (job_i.prec < body) ? body : job_i.prec;
    p     = (job_i.zpad && job_i.width > p0) ? job_i.width : p0;
    pad   = (job_i.width > p) ? job_i.width - p : 6'd0;
    lead  = job_i.left ? 6'd0 : pad;
    trail = job_i.left ? pad : 6'd0;
    b1    = lead;
    b2    = b1 + {4'd0, job_i.pfx_len};
    b3    = b2 + {5'd0, job_i.has_sign};
    b4    = b3 + (p - body);
    b5    = b4 + {1'b0, job_i.nd};
    n     = b5 + trail;
  end

  assign didx6 = b5_q - 6'd1 - k_q;
  assign d     = dig_q[didx6[4:0]];
  assign dch   = (d < 4'd10) ? iffu_pkg::ChZero + {4'd0, d}
               : (upper_q ? iffu_pkg::ChUpA : iffu_pkg::ChLowA) + {4'd0, d} - 8'd10;

  always_comb begin
    priority if (k_q < b1_q) begin
      ch = iffu_pkg::ChSpace;
    end else if (k_q < b2_q) begin
      ch = (k_q == b1_q) ? iffu_pkg::ChZero
         : (upper_q ? iffu_pkg::ChUpX : iffu_pkg::ChLowX);
    end else if (k_q < b3_q) begin
      ch = sign_q;
    end else if (k_q < b4_q) begin
      ch = iffu_pkg::ChZero;
    end else if (k_q < b5_q) begin
      ch = dch;
    end else begin
      ch = iffu_pkg::ChSpace;
    end
  end

  assign pop_o       = (state_q == BIdle) && !empty_i;
  assign emit        = (state_q == BRun) && (!ovalid_q || out_ready_i);
  assign last        = (k_q == n_q - 6'd1);
  assign out_valid_o = ovalid_q;
  assign out_char_o  = ochar_q;
  assign out_last_o  = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BIdle;
      ovalid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        state_q <= BRun;
      end else if (emit && last) begin
        state_q <= BIdle;
      end
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      k_q     <= 6'd0;
      b1_q    <= b1;
      b2_q    <= b2;
      b3_q    <= b3;
      b4_q    <= b4;
      b5_q    <= b5;
      n_q     <= n;
      dig_q   <= job_i.digits;
      sign_q  <= job_i.sign_ch;
      upper_q <= job_i.upper;
    end else if (emit) begin
      k_q <= k_q + 6'd1;
    end
    if (emit) begin
      ochar_q <= ch;
      olast_q <= last;
    end
  end

endmodule

`default_nettype wire

[rtl/integer_field_formatter_unit.sv]
// ----------------------------------------------------------------------------
// Integer field formatter
// Formats a 64-bit integer as a printf-style field, one character per ready cycle.
// ----------------------------------------------------------------------------
// Decimal items pass through the two-bits-per-cycle binary-to-BCD loop in the
// front end before their job is queued; hexadecimal and octal items skip it.
// The front end takes no new item until its job is pushed into the queue, and
// the back end pops the next job only after the last character of a field.
// Characters leave one per cycle while m_axis_tready is high.
// Reset clears the state machines, the queue and the output valid flag.
`default_nettype none

module integer_field_formatter_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // value[63:0], conversion[65:64], wide_value[66], left_align[67],
  // zero_fill[68], plus_sign[69], space_sign[70], alt_prefix[71],
  // prefix_always[72], upper_case[73], field_width[79:74], min_digits[85:80]
  input  wire logic [87:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // char_out[7:0]
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast
);

  iffu_pkg::job_t job_in, job_out;
  logic           q_push, q_pop, q_full, q_empty;

  iffu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .push_o     (q_push),
    .job_o      (job_in),
    .full_i     (q_full)
  );

  iffu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (job_out),
    .empty_o (q_empty)
  );

  iffu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("push into full queue");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("pop from empty queue");

  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("front end accepted while converting");

endmodule

`default_nettype wire

[test/integer_field_formatter_unit_tb.sv]
// ----------------------------------------------------------------------------
// Integer field formatter testbench
// Drives formatting requests and checks every emitted character and the last
// flag against a predictor, under several patterns of idle and stall cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_field_formatter_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  pad;
    logic [5:0]  min_digits;
    logic [5:0]  field_width;
    logic        upper_case;
    logic        prefix_always;
    logic        alt_prefix;
    logic        space_sign;
    logic        plus_sign;
    logic        zero_fill;
    logic        left_align;
    logic        wide_value;
    logic [1:0]  conversion;
    logic [63:0] value;
  } fmt_req_t;

  typedef struct {
    fmt_req_t req;
    string    known;
  } fmt_row_t;

  localparam int unsigned IdleGap    = 82;
  localparam int unsigned BothGap    = 12;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainWait  = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // value[63:0], conversion[65:64], wide_value[66], left_align[67],
  // zero_fill[68], plus_sign[69], space_sign[70], alt_prefix[71],
  // prefix_always[72], upper_case[73], field_width[79:74], min_digits[85:80]
  logic [87:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // char_out[7:0]
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  logic [7:0]  exp_chars[$];
  logic        exp_lasts[$];
  fmt_row_t    rows[$];
  int unsigned fails;
  int unsigned quiet_cycles;
  int unsigned send_gap;
  int unsigned recv_stall;

  integer_field_formatter_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic fmt_req_t mk(logic [63:0] value, logic [1:0] kind, bit wide, bit left,
                                  bit zero, bit plus, bit space, bit alt, bit always_pfx,
                                  bit upper, logic [5:0] width, logic [5:0] prec);
    fmt_req_t r;
    r = '0;
    r.value = value;
    r.conversion = kind;
    r.wide_value = wide;
    r.left_align = left;
    r.zero_fill = zero;
    r.plus_sign = plus;
    r.space_sign = space;
    r.alt_prefix = alt;
    r.prefix_always = always_pfx;
    r.upper_case = upper;
    r.field_width = width;
    r.min_digits = prec;
    return r;
  endfunction

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      exp_chars.push_back(s[i]);
      exp_lasts.push_back(i == s.len() - 1);
    end
  endtask

  task automatic format_field(fmt_req_t r);
    logic [63:0] mag;
    logic [63:0] m;
    logic [7:0]  sign;
    logic [7:0]  dg[24];
    int unsigned nd;
    int unsigned d;
    int unsigned base;
    int unsigned body;
    int unsigned width;
    int unsigned prec;
    bit          zpad;
    string       s;
    nd = 0;
    sign = 8'h00;
    s = "";
    zpad = r.zero_fill && !r.left_align;
    width = (r.field_width > iffu_pkg::WidthLimit) ? 32'(iffu_pkg::WidthLimit)
                                                   : 32'(r.field_width);
    prec = (r.min_digits > iffu_pkg::WidthLimit) ? 32'(iffu_pkg::WidthLimit)
                                                 : 32'(r.min_digits);
    base = (r.conversion == iffu_pkg::KindHex) ? 16 :
           (r.conversion == iffu_pkg::KindOct) ? 8 : 10;
    if (r.conversion == iffu_pkg::KindSdec) begin
      if (r.value[63]) sign = iffu_pkg::ChMinus;
      else if (r.value != 0) begin
        if (r.plus_sign) sign = iffu_pkg::ChPlus;
        else if (r.space_sign) sign = iffu_pkg::ChSpace;
      end
    end
    mag = (r.conversion == iffu_pkg::KindSdec && r.value[63]) ? 64'd0 - r.value : r.value;
    if (!r.wide_value) mag[63:32] = '0;
    m = mag;
    do begin
      d = 32'(m % 64'(base));
      m = m / 64'(base);
      dg[nd] = (d < 10) ? 8'(iffu_pkg::ChZero + d)
             : 8'((r.upper_case ? iffu_pkg::ChUpA : iffu_pkg::ChLowA) + d - 10);
      nd++;
    end while (m != 0 && nd < 24);
    body = nd + ((sign != 0) ? 1 : 0);
    if (prec < body) prec = body;
    if (zpad && width > prec) prec = width;
    if (!r.left_align) for (int i = prec; i < width; i++) s = {s, " "};
    if ((r.conversion == iffu_pkg::KindHex || r.conversion == iffu_pkg::KindOct) &&
        r.alt_prefix && (mag != 0 || r.prefix_always)) begin
      s = {s, "0"};
      if (r.conversion == iffu_pkg::KindHex) begin
        s = {s, string'(r.upper_case ? iffu_pkg::ChUpX : iffu_pkg::ChLowX)};
      end
    end
    if (sign != 0) s = {s, string'(sign)};
    for (int i = body; i < prec; i++) s = {s, "0"};
    for (int i = nd; i > 0; i--) s = {s, string'(dg[i-1])};
    if (r.left_align) for (int i = prec; i < width; i++) s = {s, " "};
    push_text(s);
  endtask

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(1000));
      2: return 64'd0 - 64'($urandom_range(1000));
      3: return {32'h0, $urandom};
      4: return {{32{1'b1}}, $urandom};
      default: return ($urandom_range(1)) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    endcase
  endfunction

  task automatic send_request(fmt_row_t row);
    while ($urandom_range(99) < send_gap) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata = row.req;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (row.known.len() != 0) push_text(row.known);
    else format_field(row.req);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (exp_chars.size() == 0) begin
        report_mismatch("unexpected character", m_axis_tdata, 8'h00);
      end else begin
        if (m_axis_tdata !== exp_chars[0]) report_mismatch("char", m_axis_tdata, exp_chars[0]);
        if (m_axis_tlast !== exp_lasts[0]) begin
          report_mismatch("last", {7'd0, m_axis_tlast}, {7'd0, exp_lasts[0]});
        end
        void'(exp_chars.pop_front());
        void'(exp_lasts.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    fmt_row_t row;
    fails = 0;
    send_gap = 0;
    recv_stall = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;

    rows.push_back('{mk(0, iffu_pkg::KindSdec, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), "0"});
    rows.push_back('{mk(-1, iffu_pkg::KindSdec, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), "-1"});
    rows.push_back('{mk(64'h8000_0000_0000_0000, iffu_pkg::KindSdec,
                        1, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                     "-9223372036854775808"});
    rows.push_back('{mk(-1, iffu_pkg::KindUdec, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                     "18446744073709551615"});
    rows.push_back('{mk(-1, iffu_pkg::KindUdec, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), "4294967295"});
    rows.push_back('{mk(-1, iffu_pkg::KindHex, 1, 0, 0, 0, 0, 1, 0, 1, 0, 0),
                     "0XFFFFFFFFFFFFFFFF"});
    rows.push_back('{mk(0, iffu_pkg::KindHex, 1, 0, 0, 0, 0, 1, 1, 0, 0, 0), "0x0"});
    rows.push_back('{mk(0, iffu_pkg::KindHex, 1, 0, 0, 0, 0, 1, 0, 0, 0, 0), "0"});
    rows.push_back('{mk(7, iffu_pkg::KindSdec, 1, 0, 0, 0, 1, 0, 0, 0, 0, 0), " 7"});
    rows.push_back('{mk(7, iffu_pkg::KindSdec, 1, 0, 0, 1, 1, 0, 0, 0, 0, 0), "+7"});
    rows.push_back('{mk(0, iffu_pkg::KindSdec, 1, 0, 0, 1, 1, 0, 0, 0, 3, 0), "  0"});
    rows.push_back('{mk(-1, iffu_pkg::KindSdec, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), ""});
    rows.push_back('{mk(-1, iffu_pkg::KindOct, 1, 0, 0, 0, 0, 1, 0, 0, 0, 0), ""});
    rows.push_back('{mk(-1, iffu_pkg::KindOct, 1, 0, 1, 0, 0, 1, 1, 1, 63, 63), ""});
    rows.push_back('{mk(5, iffu_pkg::KindSdec, 1, 0, 1, 1, 0, 0, 0, 0, 63, 0), ""});
    rows.push_back('{mk(-5, iffu_pkg::KindSdec, 1, 1, 1, 0, 0, 0, 0, 0, 61, 3), ""});
    rows.push_back('{mk(64'hDEAD_BEEF_CAFE_F00D, iffu_pkg::KindHex,
                        0, 0, 1, 1, 1, 1, 0, 1, 20, 12), ""});
    rows.push_back('{mk(42, iffu_pkg::KindUdec, 1, 0, 0, 1, 1, 1, 1, 1, 8, 63), ""});
    rows.push_back('{mk(-42, iffu_pkg::KindSdec, 1, 0, 0, 0, 0, 1, 1, 1, 0, 60), ""});
    rows.push_back('{mk(64'h1_0000_0000, iffu_pkg::KindHex,
                        0, 1, 0, 0, 0, 1, 1, 0, 62, 0), ""});
    rows.push_back('{mk(64'h7FFF_FFFF_FFFF_FFFF, iffu_pkg::KindSdec,
                        1, 1, 0, 1, 0, 0, 0, 0, 60, 60), ""});

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) send_request(rows[i]);

    for (int ph = 0; ph < 4; ph++) begin
      send_gap = (ph == 1) ? IdleGap : (ph == 3) ? BothGap : 0;
      recv_stall = (ph == 2) ? IdleGap : (ph == 3) ? BothGap : 0;
      repeat (102) begin
        row.req = 88'({$urandom, $urandom, $urandom});
        row.req.pad = '0;
        row.req.value = pick_value();
        if ($urandom_range(3) != 0) begin
          row.req.field_width = 6'($urandom_range(24));
          row.req.min_digits = 6'($urandom_range(24));
        end
        row.known = "";
        send_request(row);
      end
    end

    while (exp_chars.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (fails == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
